/* rtl/vfp_pkg.sv */
`timescale 1ns / 1ps
// vfp_pkg: shared types and constants of the voice frame parser.
// Used by vfp_frame_fsm, vfp_out_skid and voice_frame_parser.
package vfp_pkg;

    // Frame bytes: A5 FA 00 81 code 00 param FB
    localparam logic [7:0] HDR0      = 8'hA5;
    localparam logic [7:0] HDR1      = 8'hFA;
    localparam logic [7:0] HDR2      = 8'h00;
    localparam logic [7:0] HDR3      = 8'h81;
    localparam logic [7:0] WAKE_CODE = 8'h01;
    localparam logic [7:0] CODE_LIM  = 8'h40;
    localparam logic [7:0] PAD       = 8'h00;
    localparam logic [7:0] TAIL      = 8'hFB;

    // cmd codes
    localparam logic CMD_BYTE       = 1'b0;
    localparam logic CMD_WAKE_CLEAR = 1'b1;

    // Position in the frame, one-hot
    typedef enum logic [7:0] {
        POS_HDR0  = 8'b0000_0001,
        POS_HDR1  = 8'b0000_0010,
        POS_HDR2  = 8'b0000_0100,
        POS_HDR3  = 8'b0000_1000,
        POS_CODE  = 8'b0001_0000,
        POS_PAD   = 8'b0010_0000,
        POS_PARAM = 8'b0100_0000,
        POS_TAIL  = 8'b1000_0000
    } t_vfp_pos;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_vfp_in;

    typedef struct packed {
        logic       frame_done;
        logic [7:0] voice_code;
        logic [7:0] voice_param;
        logic       wake_seen;
        logic       wake_active;
    } t_vfp_out;

    // Parser state carried between words
    typedef struct packed {
        t_vfp_pos   pos;
        logic       wake;
        logic [7:0] code;
        logic [7:0] param;
    } t_vfp_state;

endpackage

/* rtl/vfp_frame_fsm.sv */
`timescale 1ns / 1ps
// vfp_frame_fsm: one-word step of the frame parser (next state and result).
// Depends on vfp_pkg.
module vfp_frame_fsm (
    input  vfp_pkg::t_vfp_state i_state,
    input  vfp_pkg::t_vfp_in    i_word,
    output vfp_pkg::t_vfp_state o_state,
    output vfp_pkg::t_vfp_out   o_result
);
    import vfp_pkg::*;

    logic       code_ok;
    logic       is_wake;
    logic       done;
    logic       seen;
    t_vfp_state nxt;

    assign is_wake = (i_word.rx_byte == WAKE_CODE);
    // non-zero and below the code limit, only while awake
    assign code_ok = i_state.wake && (i_word.rx_byte != 8'h00)
                     && (i_word.rx_byte < CODE_LIM);

    always_comb begin
        nxt  = i_state;
        done = 1'b0;
        seen = 1'b0;
        if (i_word.cmd == CMD_WAKE_CLEAR) begin
            nxt.wake = 1'b0;
        end else begin
            unique case (i_state.pos)
                POS_HDR0:  nxt.pos = (i_word.rx_byte == HDR0) ? POS_HDR1 : POS_HDR0;
                POS_HDR1:  nxt.pos = (i_word.rx_byte == HDR1) ? POS_HDR2 : POS_HDR0;
                POS_HDR2:  nxt.pos = (i_word.rx_byte == HDR2) ? POS_HDR3 : POS_HDR0;
                POS_HDR3:  nxt.pos = (i_word.rx_byte == HDR3) ? POS_CODE : POS_HDR0;
                POS_CODE: begin
                    if (is_wake) begin
                        nxt.wake = 1'b1;
                        seen     = 1'b1;
                        nxt.code = i_word.rx_byte;
                        nxt.pos  = POS_PAD;
                    end else if (code_ok) begin
                        nxt.code = i_word.rx_byte;
                        nxt.pos  = POS_PAD;
                    end else begin
                        nxt.pos  = POS_HDR0;
                    end
                end
                POS_PAD:   nxt.pos = (i_word.rx_byte == PAD) ? POS_PARAM : POS_HDR0;
                POS_PARAM: begin
                    nxt.param = i_word.rx_byte;
                    nxt.pos   = POS_TAIL;
                end
                POS_TAIL: begin
                    done    = (i_word.rx_byte == TAIL);
                    nxt.pos = POS_HDR0;
                end
                default:   nxt.pos = POS_HDR0;
            endcase
        end
    end

    assign o_state              = nxt;
    assign o_result.frame_done  = done;
    assign o_result.voice_code  = nxt.code;
    assign o_result.voice_param = nxt.param;
    assign o_result.wake_seen   = seen;
    assign o_result.wake_active = nxt.wake;

endmodule

/* rtl/vfp_out_skid.sv */
`timescale 1ns / 1ps
// vfp_out_skid: output register plus one skid entry for result words.
// Depends on vfp_pkg.
module vfp_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vfp_pkg::t_vfp_out i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output vfp_pkg::t_vfp_out o_data
);
    import vfp_pkg::*;

    logic     r_out_valid, n_out_valid;
    logic     r_skid_valid, n_skid_valid;
    t_vfp_out r_out, n_out;
    t_vfp_out r_skid, n_skid;
    logic     out_free;

    // output slot is free when empty or being taken now
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = i_data;
                n_out_valid  = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* rtl/voice_frame_parser.sv */
`timescale 1ns / 1ps
// voice_frame_parser: top level of the voice module frame parser.
// Depends on vfp_pkg, vfp_frame_fsm and vfp_out_skid.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one word per
//   cycle while o_in_ready is high: either a received serial byte
//   (cmd = byte) or a wake-window expiry (cmd = wake clear), which drops
//   the sticky wake flag. Frames look like A5 FA 00 81 code 00 param FB.
//   Code 01 is the wake word and is always taken; codes 02..3F are taken
//   only while awake. A mismatch restarts at the first header byte without
//   rechecking it. Output channel (o_out_valid / i_out_ready / o_out_data)
//   returns exactly one result word per input word, in order.
// Result: registered; it waits in the skid entry while the output is held.
// Throughput: one word per cycle unless stalled; the parser step is a single
//   one-hot FSM transition between the parser state and output registers.
// Stall: an output register plus one skid entry decouple the sides; the
//   input ready only drops once both hold a word, so ready never depends
//   combinationally on i_out_ready.
// Reset: synchronous active low; parser waits for the first header byte,
//   wake flag, held code and held parameter are zero, output is empty.
module voice_frame_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vfp_pkg::t_vfp_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vfp_pkg::t_vfp_out o_out_data
);
    import vfp_pkg::*;

    t_vfp_state r_state, n_state;
    t_vfp_state step_state;
    t_vfp_out   step_result;
    logic       in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // Parser step on the incoming word
    vfp_frame_fsm u_fsm (
        .i_state  (r_state),
        .i_word   (i_in_data),
        .o_state  (step_state),
        .o_result (step_result)
    );

    // State advances only on an accepted word
    assign n_state = in_acc ? step_state : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos   <= POS_HDR0;
            r_state.wake  <= 1'b0;
            r_state.code  <= 8'h00;
            r_state.param <= 8'h00;
        end else begin
            r_state <= n_state;
        end
    end

    // Result register and skid entry
    vfp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_data  (step_result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // Wake clear always leaves the flag low
    a_wake_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.cmd == CMD_WAKE_CLEAR) |=> !r_state.wake)
        else $error("wake flag still set after wake clear");

    // Wake code at the code position sets the flag
    a_wake_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.cmd == CMD_BYTE) && (r_state.pos == POS_CODE)
        && (i_in_data.rx_byte == WAKE_CODE) |=> r_state.wake)
        else $error("wake code did not set wake flag");

    // Input stalls only while a result is waiting at the output
    a_stall_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // A wake-seen result always shows the flag active
    a_seen_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.wake_seen |-> o_out_data.wake_active)
        else $error("wake seen without wake active");
`endif

endmodule
